/* sv/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types, widths and the modular shift-add step for the exponentiator
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int MOD_W  = 31;
    localparam int BASE_W = 63;
    localparam int CNT_W  = 6;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    // register indexes
    localparam logic [1:0] REG_MODULUS = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_BIT,
        ST_MUL,
        ST_MEND,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_STEP,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_MUL_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   in_ready;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic special;
        logic cnt_zero;
        logic exp_zero;
    } dp_status_t;

    // one msb-first shift-add step: (2p + bit*a) mod m, with p < m and a <= m
    function automatic logic [MOD_W-1:0] mm_step(
        input logic [MOD_W-1:0] p,
        input logic [MOD_W-1:0] a,
        input logic             b,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W+2:0] s;
        logic [MOD_W+2:0] m1;
        logic [MOD_W+2:0] m2;
        logic [MOD_W+2:0] r;
        s  = {2'b00, p, 1'b0} + (b ? {3'b000, a} : '0);
        m1 = {3'b000, m};
        m2 = {2'b00, m, 1'b0};
        if (s >= m2)
        begin
            r = s - m2;
        end
        else if (s >= m1)
        begin
            r = s - m1;
        end
        else
        begin
            r = s;
        end
        return r[MOD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for base reduction and the square-and-multiply bit loop
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       out_free,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.special ? ST_FINISH : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.op = OP_RED_STEP;
                if (status.cnt_zero)
                begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = OP_MUL_INIT;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                if (status.cnt_zero)
                begin
                    state_next = ST_MEND;
                end
            end
            ST_MEND:
            begin
                cmd.op     = OP_MUL_END;
                state_next = ST_BIT;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/mexp_dp.sv */
// ----------------------------------------------------------------------------
// mexp_dp
// datapath: bit-serial base reduction and two shift-add modular multipliers
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 63
)
(
    input  wire logic                clk,
    input  wire dp_cmd_t             cmd,
    input  wire logic                kind,
    input  wire logic [BASE_W-1:0]   base,
    input  wire logic [EXP_BITS-1:0] exponent,
    input  wire logic [MOD_W-1:0]    modulus,
    output dp_status_t               status,
    output logic [MOD_W-1:0]         result
);

    logic [BASE_W-1:0]   base_reg;
    logic [BASE_W-1:0]   exp_reg;    // full width so the inverse exponent is never cut
    logic [MOD_W-1:0]    sq_reg;     // reduced base, then running square
    logic [MOD_W-1:0]    acc_reg;
    logic [MOD_W-1:0]    mplier_reg;
    logic [MOD_W-1:0]    pacc_reg;
    logic [MOD_W-1:0]    psq_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                one_reg;
    logic                zero_reg;

    logic [BASE_W-1:0]   inv_wide;
    logic [BASE_W-1:0]   exp_sel;
    logic [MOD_W:0]      red_sum;

    assign inv_wide = BASE_W'(modulus) - BASE_W'(2);
    assign exp_sel  = kind ? inv_wide : BASE_W'(exponent);
    assign red_sum  = {sq_reg, base_reg[BASE_W-1]};

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                base_reg <= base;
                exp_reg  <= exp_sel;
                sq_reg   <= '0;
                acc_reg  <= MOD_W'(1);
                cnt_reg  <= CNT_W'(BASE_W - 1);
                one_reg  <= (exp_sel == '0) || (kind && (modulus < MOD_W'(3)));
                zero_reg <= (modulus == '0);
            end
            OP_RED_STEP:
            begin
                if (red_sum >= {1'b0, modulus})
                begin
                    sq_reg <= MOD_W'(red_sum - {1'b0, modulus});
                end
                else
                begin
                    sq_reg <= red_sum[MOD_W-1:0];
                end
                base_reg <= {base_reg[BASE_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            OP_MUL_INIT:
            begin
                mplier_reg <= sq_reg;
                pacc_reg   <= '0;
                psq_reg    <= '0;
                cnt_reg    <= CNT_W'(MOD_W - 1);
            end
            OP_MUL_STEP:
            begin
                pacc_reg   <= mm_step(pacc_reg, acc_reg, mplier_reg[MOD_W-1], modulus);
                psq_reg    <= mm_step(psq_reg, sq_reg, mplier_reg[MOD_W-1], modulus);
                mplier_reg <= {mplier_reg[MOD_W-2:0], 1'b0};
                cnt_reg    <= cnt_reg - CNT_W'(1);
            end
            OP_MUL_END:
            begin
                if (exp_reg[0])
                begin
                    acc_reg <= pacc_reg;
                end
                sq_reg  <= psq_reg;
                exp_reg <= exp_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    assign status.special  = one_reg || zero_reg;
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.exp_zero = (exp_reg == '0);

    always_comb
    begin
        if (one_reg)
        begin
            result = MOD_W'(1);
        end
        else if (zero_reg)
        begin
            result = '0;
        end
        else
        begin
            result = acc_reg;
        end
    end

endmodule

`default_nettype wire

/* sv/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// right-to-left square and multiply modulo a configured modulus, with a
// fermat inverse mode
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tuser = kind, s_tdata = base, exponent
//  m_*       out  m_tvalid / m_tready       m_tdata = result
//  apb       in   psel, penable, pwrite     paddr, pwdata, prdata (modulus at 0x0)
//
//  an item runs a bit-serial base reduction, then a shift-add multiply pair
//  per exponent bit up to n, n being the position of the highest set
//  exponent bit plus one (the modulus minus 2 for an inverse). trivial cases
//  (zero exponent, modulus below 3 for an inverse, zero modulus) skip both.
//  reset clears the sequencer and the output beat and loads the modulus with
//  1000000007. a finished result waits in the output register, and the next
//  beat is taken meanwhile; a new result stalls until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 63
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input beats
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [62:0] base, [125:63] exponent, zero pad
    input  wire logic         s_tuser,   // [0] kind: 0 power, 1 inverse
    // result beats
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // [30:0] result, zero pad
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [MOD_W-1:0] modulus_reg;
    logic             m_tvalid_reg;
    logic [MOD_W-1:0] result_reg;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [MOD_W-1:0] dp_result;
    logic             out_free;

    // configuration register, written on the access phase only
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (psel && penable && pwrite && (paddr == REG_MODULUS))
        begin
            modulus_reg <= pwdata[MOD_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_MODULUS: prdata = {1'b0, modulus_reg};
            default:     prdata = '0;
        endcase
    end

    // output register: free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg <= dp_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg};
    assign s_tready = cmd.in_ready;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    // only the low EXP_BITS exponent bits take part
    mexp_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .kind     (s_tuser),
        .base     (s_tdata[BASE_W-1:0]),
        .exponent (s_tdata[BASE_W+EXP_BITS-1:BASE_W]),
        .modulus  (modulus_reg),
        .status   (status),
        .result   (dp_result)
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the square and multiply exponentiator against a bit-exact predictor:
// directed corner beats, then random powers and inverses under several moduli
// (reset value, 998244353, the largest, 1, 2, 0, 3 and a random one), with
// random idle bursts on both streams and modulus writes only while drained
// ----------------------------------------------------------------------------

module testbench;

    import mexp_pkg::*;

    // item kinds carried on s_tuser
    localparam logic KIND_POWER   = 1'b0;
    localparam logic KIND_INVERSE = 1'b1;

    // one item as the sender sees it
    typedef struct {
        logic              kind;
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] exponent;
    } modexp_req_t;

    localparam logic [BASE_W-1:0] FIELD_MAX = '1;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every input starts at a known value
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;   // [62:0] base, [125:63] exponent, zero pad
    logic         s_tuser  = 1'b0; // [0] kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;         // [30:0] result, zero pad
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [1:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    // items waiting for the driver, and results owed by the block
    modexp_req_t       pending_reqs[$];
    logic [MOD_W-1:0]  expected_results[$];

    // modulus as the predictor sees it
    logic [MOD_W-1:0]  modulus_now = MODULUS_RESET;

    // beat currently on the input stream
    modexp_req_t       beat_now;
    logic [MOD_W-1:0]  want;

    int  send_gap   = 0;
    int  recv_stall = 0;
    bit  quiet      = 1'b0;  // no idling in the closing stretch
    int  errors     = 0;

    always #6 clk = ~clk;

    modular_exponentiation uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // predictor: right-to-left square and multiply in 64-bit arithmetic;
    // operands stay below 2^31 so every product fits
    // ------------------------------------------------------------------------
    function automatic logic [MOD_W-1:0] modexp_predict(
        input logic              kind,
        input logic [BASE_W-1:0] base,
        input logic [BASE_W-1:0] exponent,
        input logic [MOD_W-1:0]  m
    );
        longint unsigned e;
        longint unsigned mm;
        longint unsigned acc;
        longint unsigned sq;
        if (kind == KIND_INVERSE)
        begin
            // fermat: exponent is m - 2, nothing to raise when m is below 3
            if (m < 3)
            begin
                return MOD_W'(1);
            end
            e = longint'(m) - 2;
        end
        else
        begin
            e = {1'b0, exponent};
        end
        // zero exponent gives 1 even for modulus 0 or 1
        if (e == 0)
        begin
            return MOD_W'(1);
        end
        // zero modulus: no division, anything else gives 0
        if (m == 0)
        begin
            return '0;
        end
        mm  = m;
        acc = 1;
        sq  = {1'b0, base} % mm;
        while (e != 0)
        begin
            if (e[0])
            begin
                acc = (acc * sq) % mm;
            end
            sq = (sq * sq) % mm;
            e  = e >> 1;
        end
        return acc[MOD_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // driver: predicts on every accepted beat, then loads the next one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.insert(expected_results.size(),
                                        modexp_predict(beat_now.kind, beat_now.base,
                                                       beat_now.exponent, modulus_now));
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    beat_now = pending_reqs.pop_front();
                    s_tdata  <= {2'b00, beat_now.exponent, beat_now.base};
                    s_tuser  <= beat_now.kind;
                    s_tvalid <= 1'b1;
                    // idle burst after this beat, now and then
                    if (!quiet && $urandom_range(0, 4) == 0)
                    begin
                        send_gap = $urandom_range(1, 11);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result beat against the oldest prediction, and
    // stalls the result stream in random bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result: no beat expected, actual %0d", m_tdata[MOD_W-1:0]);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[MOD_W-1:0] !== want)
                    begin
                        $error("result: expected %0d, actual %0d", want, m_tdata[MOD_W-1:0]);
                        errors++;
                    end
                end
            end
            if (recv_stall != 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    recv_stall = $urandom_range(1, 11);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_req(
        input logic              kind,
        input logic [BASE_W-1:0] base,
        input logic [BASE_W-1:0] exponent
    );
        modexp_req_t req;
        req.kind     = kind;
        req.base     = base;
        req.exponent = exponent;
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    // random items: full-width values, small ones, values around the modulus,
    // and exponents of every length
    task automatic add_random(input int count);
        logic [63:0]       r;
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] exponent;
        for (int i = 0; i < count; i++)
        begin
            r = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0:       base = r[BASE_W-1:0];
                1:       base = BASE_W'($urandom_range(0, 15));
                2:       base = BASE_W'(modulus_now) + BASE_W'($urandom_range(0, 2)) - 1;
                3:       base = FIELD_MAX;
                4:       base = BASE_W'(r[MOD_W-1:0]);
                default: base = r[BASE_W-1:0] >> $urandom_range(0, 62);
            endcase
            r = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0:       exponent = '0;
                1:       exponent = FIELD_MAX;
                2:       exponent = r[BASE_W-1:0];
                default: exponent = r[BASE_W-1:0] >> $urandom_range(1, 62);
            endcase
            add_req($urandom_range(0, 1) ? KIND_INVERSE : KIND_POWER, base, exponent);
        end
    endtask

    // sender holds off until the block has delivered everything it owes
    task automatic wait_drained;
        do
        begin
            @(negedge clk);
        end
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // apb write: setup cycle, then access cycle; pready is always high
    task automatic set_modulus(input logic [MOD_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(REG_MODULUS * 4);
        pwdata  <= {1'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        modulus_now = value;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset modulus 1e9+7: directed corners first
        add_req(KIND_POWER,   63'd2, 63'd10);
        add_req(KIND_POWER,   63'd0, 63'd0);          // zero to the zero gives 1
        add_req(KIND_POWER,   63'd0, 63'd5);
        add_req(KIND_POWER,   FIELD_MAX, FIELD_MAX);  // both fields at their top
        add_req(KIND_POWER,   FIELD_MAX, 63'd1);      // base reduced before use
        add_req(KIND_POWER,   BASE_W'(MODULUS_RESET) - 1, 63'd2);
        add_req(KIND_INVERSE, 63'd2, 63'd0);
        add_req(KIND_INVERSE, 63'd0, 63'd0);          // base not invertible
        add_req(KIND_INVERSE, BASE_W'(MODULUS_RESET), FIELD_MAX); // exponent ignored
        add_req(KIND_INVERSE, FIELD_MAX, 63'd3);
        add_random(20);
        wait_drained;

        set_modulus(31'd998244353);
        add_random(30);
        wait_drained;

        // largest modulus
        set_modulus('1);
        add_req(KIND_INVERSE, 63'd3, 63'd0);
        add_req(KIND_POWER,   63'h7fffffff, 63'd7);   // multiple of the modulus
        add_req(KIND_POWER,   63'h7ffffffe, FIELD_MAX);
        add_random(30);
        wait_drained;

        // modulus one: zero exponent and inverses still give 1, anything else 0
        set_modulus(31'd1);
        add_req(KIND_POWER,   63'd5, 63'd0);
        add_req(KIND_POWER,   63'd5, 63'd3);
        add_req(KIND_INVERSE, 63'd5, 63'd9);
        add_random(8);
        wait_drained;

        // modulus two: inverse has no positive exponent
        set_modulus(31'd2);
        add_req(KIND_INVERSE, 63'd3, 63'd0);
        add_req(KIND_POWER,   63'd3, 63'd4);
        add_random(5);
        wait_drained;

        // modulus zero: no division anywhere
        set_modulus(31'd0);
        add_req(KIND_POWER,   63'd7, 63'd0);
        add_req(KIND_POWER,   63'd7, 63'd2);
        add_req(KIND_INVERSE, 63'd7, 63'd2);
        add_random(5);
        wait_drained;

        set_modulus(31'd3);
        add_random(10);
        wait_drained;

        // closing stretch at full rate under a random odd modulus
        set_modulus(31'($urandom_range(3, 32'h7fffffff)) | 31'd1);
        quiet = 1'b1;
        add_random(25);
        wait_drained;

        // room for a stray result beat
        repeat (2200) @(posedge clk);
        if (errors == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #20000000;
        $display("testbench failed");
        $finish;
    end

endmodule
